### rtl/core/tcw_pkg.sv
// Shared constants, types and helpers of the text console writer.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int ADDR_W  = $clog2(CELL_COUNT);
  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 4;
  localparam int MODE_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = COLOR_W;

  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;
  localparam logic [CELL_W-1:0]  RESET_BLANK = 16'h0F20;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic             scroll;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cur_upd_t;

  typedef struct packed {
    logic              valid;
    logic [CELL_W-1:0] cell_val;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scrolled;
  } fin_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] bg,
                                                  input logic [COLOR_W-1:0] fg,
                                                  input logic [CHAR_W-1:0]  ch);
    make_cell = {bg, fg, ch};
  endfunction

endpackage

### rtl/core/tcw_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
module tcw_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 11,
  parameter int DEPTH  = 2000
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/tcw_cursor.sv
// Cursor update for one character byte: control codes, line wrap and scroll detect.
module tcw_cursor import tcw_pkg::*; (
  input  logic [COL_W-1:0]  cur_col,
  input  logic [ROW_W-1:0]  cur_row,
  input  logic [CHAR_W-1:0] char_code,
  output cur_upd_t          upd
);

  localparam logic [COL_W:0] TabStep = (COL_W + 1)'(TAB_WIDTH);

  logic [COL_W:0] col;
  logic [ROW_W:0] row;
  logic           printable;
  logic           scroll;

  always_comb begin
    col       = {1'b0, cur_col};
    row       = {1'b0, cur_row};
    printable = (char_code >= CH_SPACE) && (char_code <= CH_LAST);
    unique case (char_code)
      CH_BS: begin
        if (cur_col != '0) begin
          col = col - 1'b1;
        end
      end
      CH_TAB: begin
        col = col + TabStep - (col % TabStep);
      end
      CH_CR: begin
        col = '0;
      end
      CH_LF: begin
        col = '0;
        row = row + 1'b1;
      end
      default: begin
        if (printable) begin
          col = col + 1'b1;
        end
      end
    endcase
    if (col >= (COL_W + 1)'(COLUMNS)) begin
      col = '0;
      row = row + 1'b1;
    end
    scroll = row >= (ROW_W + 1)'(ROWS);
    if (scroll) begin
      row = (ROW_W + 1)'(ROWS - 1);
    end
  end

  assign upd.wr_en  = printable;
  assign upd.scroll = scroll;
  assign upd.col    = col[COL_W-1:0];
  assign upd.row    = row[ROW_W-1:0];

endmodule

### rtl/core/tcw_seq.sv
// Item sequencer: cursor state, cell writes and reads, clear and scroll sweeps.
module tcw_seq import tcw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [MODE_W-1:0]  in_mode,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic [ROW_W-1:0]   in_read_row,
  input  logic [COL_W-1:0]   in_read_col,
  input  logic [COLOR_W-1:0] fg_color,
  input  logic [COLOR_W-1:0] bg_color,
  input  logic               out_free,
  output fin_t               fin,
  output logic               ram_we,
  output logic [ADDR_W-1:0]  ram_waddr,
  output logic [CELL_W-1:0]  ram_wdata,
  output logic [ADDR_W-1:0]  ram_raddr,
  input  logic [CELL_W-1:0]  ram_rdata
);

  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] CopyEnd  = ADDR_W'(COPY_CELLS);
  localparam logic [ADDR_W-1:0] RowStep  = ADDR_W'(COLUMNS);

  state_t state_r, state_nxt;

  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;
  logic              pend_r, pend_nxt;
  logic              src_fill_r, src_fill_nxt;
  logic              copy_en_r, copy_en_nxt;
  logic              report_r, report_nxt;
  logic [CELL_W-1:0] fill_r, fill_nxt;
  logic [CELL_W-1:0] res_cell_r, res_cell_nxt;
  logic              scr_r, scr_nxt;

  cur_upd_t          upd;
  logic              start_sweep;
  logic [ADDR_W:0]   in_addr;
  logic [ADDR_W-1:0] cur_addr;

  tcw_cursor u_cursor (
    .cur_col   (cur_col_r),
    .cur_row   (cur_row_r),
    .char_code (char_r),
    .upd       (upd)
  );

  assign in_addr  = (ADDR_W + 1)'(in_read_row) * (ADDR_W + 1)'(COLUMNS)
                  + (ADDR_W + 1)'(in_read_col);
  assign cur_addr = ADDR_W'(cur_row_r) * RowStep + ADDR_W'(cur_col_r);

  assign start_sweep = (state_r == ST_EXEC)
                    && ((mode_r == MODE_CLEAR) || ((mode_r == MODE_PUT) && upd.scroll));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (start_sweep) begin
          state_nxt = ST_SWEEP;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_SWEEP: begin
        if (ptr_r == LastAddr) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!report_r || out_free) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    mode_nxt     = mode_r;
    char_nxt     = char_r;
    rd_ok_nxt    = rd_ok_r;
    ptr_nxt      = ptr_r;
    dst_nxt      = dst_r;
    pend_nxt     = pend_r;
    src_fill_nxt = src_fill_r;
    copy_en_nxt  = copy_en_r;
    report_nxt   = report_r;
    fill_nxt     = fill_r;
    res_cell_nxt = res_cell_r;
    scr_nxt      = scr_r;
    ram_raddr    = in_addr[ADDR_W-1:0];
    in_stall     = (state_r != ST_IDLE);
    fin.valid    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          char_nxt  = in_char_code;
          rd_ok_nxt = (in_read_row < ROW_W'(ROWS)) && (in_read_col < COL_W'(COLUMNS));
        end
      end
      ST_EXEC: begin
        res_cell_nxt = ((mode_r == MODE_READ) && rd_ok_r) ? ram_rdata : '0;
        scr_nxt      = 1'b0;
        if (mode_r == MODE_PUT) begin
          cur_col_nxt = upd.col;
          cur_row_nxt = upd.row;
          scr_nxt     = upd.scroll;
        end else if (mode_r == MODE_CLEAR) begin
          cur_col_nxt = '0;
          cur_row_nxt = '0;
        end
        if (start_sweep) begin
          ptr_nxt     = '0;
          copy_en_nxt = (mode_r == MODE_PUT);
          report_nxt  = 1'b1;
          fill_nxt    = make_cell(bg_color, fg_color, CH_SPACE);
        end
        fin.valid = !start_sweep;
      end
      ST_SWEEP: begin
        ram_raddr    = ptr_r + RowStep;
        ptr_nxt      = ptr_r + 1'b1;
        pend_nxt     = 1'b1;
        dst_nxt      = ptr_r;
        src_fill_nxt = !copy_en_r || (ptr_r >= CopyEnd);
      end
      ST_DRAIN: begin
        pend_nxt  = 1'b0;
        fin.valid = report_r;
      end
      ST_HOLD: begin
        fin.valid = 1'b1;
      end
      default: begin
        fin.valid = 1'b0;
      end
    endcase

    fin.cell_val = res_cell_nxt;
    fin.col      = cur_col_nxt;
    fin.row      = cur_row_nxt;
    fin.scrolled = scr_nxt;

    if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = dst_r;
      ram_wdata = src_fill_r ? fill_r : ram_rdata;
    end else begin
      ram_we    = (state_r == ST_EXEC) && (mode_r == MODE_PUT) && upd.wr_en;
      ram_waddr = cur_addr;
      ram_wdata = make_cell(bg_color, fg_color, char_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_SWEEP;
      cur_col_r <= '0;
      cur_row_r <= '0;
      ptr_r     <= '0;
      pend_r    <= 1'b0;
      copy_en_r <= 1'b0;
      report_r  <= 1'b0;
      fill_r    <= RESET_BLANK;
    end else begin
      state_r   <= state_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      ptr_r     <= ptr_nxt;
      pend_r    <= pend_nxt;
      copy_en_r <= copy_en_nxt;
      report_r  <= report_nxt;
      fill_r    <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    char_r     <= char_nxt;
    rd_ok_r    <= rd_ok_nxt;
    dst_r      <= dst_nxt;
    src_fill_r <= src_fill_nxt;
    res_cell_r <= res_cell_nxt;
    scr_r      <= scr_nxt;
  end

endmodule

### rtl/core/text_console_writer_core.sv
// Text console writer: an 80x25 cell store with cursor, colour registers and result register.
// A put-character, cell read or unused-mode beat is executed in the cycle after acceptance and
// its result is loaded into the output register when that register is free; the next beat is
// taken only once the sequencer is idle again, not while a beat is still in work; the cell store
// is a single RAM with one write and one registered read port, and the cursor update and cell
// write share the cycle after acceptance. A clear, or a character that scrolls the screen, walks
// every cell of the store at one cell a cycle: a scroll copies each row up one, then blanks the
// bottom row, and a clear blanks every cell. After reset the store is cleared to blanks, during
// which in_stall stays high; configuration writes are taken at any time. A finished result waits
// in the output register while the next beat is accepted.
module text_console_writer_core import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [ROW_W-1:0]      in_read_row,
  input  logic [COL_W-1:0]      in_read_col,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CELL_W-1:0]     out_cell_value,
  output logic [COL_W-1:0]      out_cursor_col,
  output logic [ROW_W-1:0]      out_cursor_row,
  output logic                  out_scrolled,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COLOR_W-1:0] fg_r, fg_nxt;
  logic [COLOR_W-1:0] bg_r, bg_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]  cell_r, cell_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               scr_r, scr_nxt;
  logic               out_free;
  fin_t               fin;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  tcw_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_char_code (in_char_code),
    .in_read_row  (in_read_row),
    .in_read_col  (in_read_col),
    .fg_color     (fg_r),
    .bg_color     (bg_r),
    .out_free     (out_free),
    .fin          (fin),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  tcw_ram #(
    .DATA_W (CELL_W),
    .ADDR_W (ADDR_W),
    .DEPTH  (CELL_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FG:  fg_nxt = cfg_data;
        CFG_BG:  bg_nxt = cfg_data;
        default: fg_nxt = fg_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    cell_nxt      = cell_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    scr_nxt       = scr_r;
    if (fin.valid && out_free) begin
      out_valid_nxt = 1'b1;
      cell_nxt      = fin.cell_val;
      col_nxt       = fin.col;
      row_nxt       = fin.row;
      scr_nxt       = fin.scrolled;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r        <= FG_RESET;
      bg_r        <= BG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    scr_r  <= scr_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = cell_r;
  assign out_cursor_col = col_r;
  assign out_cursor_row = row_r;
  assign out_scrolled   = scr_r;

endmodule

### rtl/core/tcw_checker.sv
// Port-level checks of the text console writer, bound to the top level.
module tcw_assertions import tcw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CELL_W-1:0] out_cell_value,
  input logic [COL_W-1:0]  out_cursor_col,
  input logic [ROW_W-1:0]  out_cursor_row,
  input logic              out_scrolled
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_cell_value) && $stable(out_cursor_col)
                               && $stable(out_cursor_row) && $stable(out_scrolled))
    else $error("stalled result beat changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_col < COL_W'(COLUMNS)) && (out_cursor_row < ROW_W'(ROWS)))
    else $error("cursor outside the screen");

  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |-> (out_cursor_col == '0)
                                  && (out_cursor_row == ROW_W'(ROWS - 1)))
    else $error("scroll left cursor off the start of the bottom row");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input beat taken while previous beat still in work");

endmodule

bind text_console_writer_core tcw_assertions u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_cell_value (out_cell_value),
  .out_cursor_col (out_cursor_col),
  .out_cursor_row (out_cursor_row),
  .out_scrolled   (out_scrolled)
);
